/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/vmrab_pkg.sv */
// Types and constants of the VM register / ALU / branch execute unit.
package vmrab_pkg;

  localparam int unsigned WORD_W       = 64;
  localparam int unsigned SLOT_W       = 8;
  localparam int unsigned TGT_W        = 32;
  localparam int unsigned OP_W         = 4;
  localparam int unsigned OUT_PC_W     = 32;
  localparam int unsigned CNT_W        = $clog2(WORD_W);
  localparam int unsigned DEF_NUM_REGS = 256;
  localparam int unsigned DEF_PC_WIDTH = 32;

  typedef enum logic [OP_W-1:0] {
    OP_CMP  = 4'd0,
    OP_BEQ  = 4'd1,
    OP_BNE  = 4'd2,
    OP_JUMP = 4'd3,
    OP_ADD  = 4'd4,
    OP_SUB  = 4'd5,
    OP_MUL  = 4'd6,
    OP_DIV  = 4'd7,
    OP_MOVE = 4'd8,
    OP_COPY = 4'd9
  } opcode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_EXEC,
    ST_ITER,
    ST_WRITE,
    ST_CLR_SRC,
    ST_DONE
  } state_t;

endpackage

/* rtl/vm_register_alu_branch_unit.sv */
// Execute unit of a small register VM: register file, pc and iterative ALU.
//
// Executes one instruction per request against a file of NUM_REGS 64-bit
// registers and a PC_WIDTH-bit program counter, and returns one result
// (pc after the instruction, the value written, and a wrote flag) per
// request. After reset the register file is swept to zero one entry per
// cycle, so the block stalls its input until the sweep is done. The block
// works on one request at a time: it reads both sources, executes, writes
// the result back (a move then also clears its source) and loads the
// result; the branches, jump and unused opcodes skip the write back. Mul
// and a divide by a nonzero divisor run through a single 65-bit
// add/subtract unit one bit per cycle (shift-add multiply, restoring
// divide), 64 steps, before the write back. The block returns to idle
// before it accepts the next request. The register file is a
// single-write-port memory with registered reads; both sources are read in
// consecutive cycles over one read port. Slots at or above NUM_REGS read
// as zero and writes to them are dropped. Divide by zero writes zero.
// Results sit in an output register, so a stalled result does not block
// the next request from being taken.
`include "assert_macros.svh"

module vm_register_alu_branch_unit
  import vmrab_pkg::*;
#(
  parameter int unsigned NUM_REGS = DEF_NUM_REGS,
  parameter int unsigned PC_WIDTH = DEF_PC_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     opcode,
  input  logic [SLOT_W-1:0]   src_a,
  input  logic [SLOT_W-1:0]   src_b,
  input  logic [SLOT_W-1:0]   dest,
  input  logic [TGT_W-1:0]    target_a,
  input  logic [TGT_W-1:0]    target_b,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [OUT_PC_W-1:0] pc_value,
  output logic [WORD_W-1:0]   written_value,
  output logic                wrote
);

  localparam int unsigned AW = $clog2(NUM_REGS);

  // sequencer
  state_t            state, state_next;
  logic [AW-1:0]     clr_idx, clr_idx_next;
  logic [PC_WIDTH-1:0] pc, pc_next;

  // latched request
  opcode_t           op_q;
  logic [SLOT_W-1:0] sa_q, sb_q, dst_q;
  logic [TGT_W-1:0]  ta_q, tb_q;

  // working registers: acc = product / remainder, opa = multiplicand /
  // dividend-quotient, opb = multiplier / divisor
  logic [WORD_W-1:0] acc, acc_next;
  logic [WORD_W-1:0] opa, opa_next;
  logic [WORD_W-1:0] opb, opb_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [WORD_W-1:0] res, res_next;
  logic              did, did_next;
  logic [SLOT_W-1:0] wslot, wslot_next;

  // register file
  logic [WORD_W-1:0] mem [NUM_REGS];
  logic [WORD_W-1:0] rd_data;
  logic [AW-1:0]     rd_addr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  // shared add/subtract unit
  logic [WORD_W:0]   unit_x, unit_y;
  logic              unit_sub;
  logic [WORD_W+1:0] unit_sum;
  logic              unit_carry;
  logic              eq;

  logic              load_out;
  logic              sa_ok, sb_ok, dst_ok;
  logic [WORD_W-1:0] vb;

  assign in_stall = (state != ST_IDLE);

  assign sa_ok  = (32'(sa_q)  < 32'(NUM_REGS));
  assign sb_ok  = (32'(sb_q)  < 32'(NUM_REGS));
  assign dst_ok = (32'(dst_q) < 32'(NUM_REGS));

  // second operand straight from the read port (valid in ST_EXEC)
  assign vb = sb_ok ? rd_data : '0;

  assign unit_sum = {1'b0, unit_x} + {1'b0, unit_y ^ {(WORD_W+1){unit_sub}}}
                    + (WORD_W+2)'(unit_sub);
  assign unit_carry = unit_sum[WORD_W+1];
  assign eq = (unit_sum[WORD_W-1:0] == '0);

  always_comb begin
    state_next   = state;
    clr_idx_next = clr_idx;
    pc_next      = pc;
    acc_next     = acc;
    opa_next     = opa;
    opb_next     = opb;
    cnt_next     = cnt;
    res_next     = res;
    did_next     = did;
    wslot_next   = wslot;
    rd_addr      = AW'(sa_q);
    mem_we       = 1'b0;
    mem_waddr    = clr_idx;
    mem_wdata    = '0;
    unit_x       = '0;
    unit_y       = '0;
    unit_sub     = 1'b0;
    load_out     = 1'b0;

    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_idx == AW'(NUM_REGS - 1)) begin
          state_next = ST_IDLE;
        end else begin
          clr_idx_next = clr_idx + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_RD_A;
        end
      end
      ST_RD_A: begin
        rd_addr    = AW'(sa_q);
        state_next = ST_RD_B;
      end
      ST_RD_B: begin
        rd_addr    = AW'(sb_q);
        opa_next   = sa_ok ? rd_data : '0;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        unit_x     = {1'b0, opa};
        unit_y     = {1'b0, vb};
        unit_sub   = (op_q != OP_ADD);
        state_next = ST_WRITE;
        res_next   = '0;
        did_next   = 1'b0;
        wslot_next = dst_q;
        unique case (op_q) inside
          OP_CMP: begin
            res_next   = WORD_W'(eq);
            did_next   = 1'b1;
            wslot_next = '0;
          end
          OP_BEQ: begin
            pc_next    = eq ? PC_WIDTH'(ta_q) : PC_WIDTH'(tb_q);
            state_next = ST_DONE;
          end
          OP_BNE: begin
            pc_next    = eq ? PC_WIDTH'(tb_q) : PC_WIDTH'(ta_q);
            state_next = ST_DONE;
          end
          OP_JUMP: begin
            pc_next    = PC_WIDTH'(ta_q);
            state_next = ST_DONE;
          end
          OP_ADD, OP_SUB: begin
            res_next = unit_sum[WORD_W-1:0];
            did_next = dst_ok;
          end
          OP_MUL: begin
            acc_next   = '0;
            opb_next   = vb;
            cnt_next   = '0;
            state_next = ST_ITER;
          end
          OP_DIV: begin
            if (vb == '0) begin
              did_next = dst_ok;
            end else begin
              acc_next   = '0;
              opb_next   = vb;
              cnt_next   = '0;
              state_next = ST_ITER;
            end
          end
          OP_MOVE: begin
            // move onto itself ends with the register cleared
            res_next   = (sa_q == sb_q) ? '0 : opa;
            did_next   = sb_ok;
            wslot_next = sb_q;
          end
          OP_COPY: begin
            res_next   = opa;
            did_next   = sb_ok;
            wslot_next = sb_q;
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end
      ST_ITER: begin
        cnt_next = cnt + 1'b1;
        if (op_q == OP_MUL) begin
          unit_x   = {1'b0, acc};
          unit_y   = opb[0] ? {1'b0, opa} : '0;
          acc_next = unit_sum[WORD_W-1:0];
          opa_next = {opa[WORD_W-2:0], 1'b0};
          opb_next = {1'b0, opb[WORD_W-1:1]};
        end else begin
          // restoring divide step
          unit_x   = {acc, opa[WORD_W-1]};
          unit_y   = {1'b0, opb};
          unit_sub = 1'b1;
          acc_next = unit_carry ? unit_sum[WORD_W-1:0] : unit_x[WORD_W-1:0];
          opa_next = {opa[WORD_W-2:0], unit_carry};
        end
        if (cnt == CNT_W'(WORD_W - 1)) begin
          res_next   = (op_q == OP_MUL) ? unit_sum[WORD_W-1:0] :
                                          {opa[WORD_W-2:0], unit_carry};
          did_next   = dst_ok;
          wslot_next = dst_q;
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        mem_we     = did;
        mem_waddr  = AW'(wslot);
        mem_wdata  = res;
        state_next = (op_q == OP_MOVE) ? ST_CLR_SRC : ST_DONE;
      end
      ST_CLR_SRC: begin
        mem_we     = sa_ok;
        mem_waddr  = AW'(sa_q);
        mem_wdata  = '0;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
      pc      <= pc_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_q  <= opcode_t'(opcode);
      sa_q  <= src_a;
      sb_q  <= src_b;
      dst_q <= dest;
      ta_q  <= target_a;
      tb_q  <= target_b;
    end
    acc   <= acc_next;
    opa   <= opa_next;
    opb   <= opb_next;
    cnt   <= cnt_next;
    res   <= res_next;
    did   <= did_next;
    wslot <= wslot_next;
    if (load_out) begin
      pc_value      <= OUT_PC_W'(pc);
      written_value <= did ? res : '0;
      wrote         <= did;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  `ASSERT_NEXT(a_accept_reads, (in_valid && !in_stall), (state == ST_RD_A), "accepted request did not start a register read")
  `ASSERT_ALWAYS(a_iter_op, (state != ST_ITER) || (op_q == OP_MUL) || (op_q == OP_DIV), "iteration running for an op that needs none")
  `ASSERT_ALWAYS(a_clear_quiet, (state != ST_CLEAR) || (in_stall && !out_valid), "activity during register file clear")
  `ASSERT_ALWAYS(a_nowrite_zero, !out_valid || wrote || (written_value == '0), "nonzero value reported without a write")

endmodule

/* sim/vm_register_alu_branch_unit_test.sv */
// Testbench for the VM register / ALU / branch execute unit.
module vm_register_alu_branch_unit_test
  import vmrab_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Run shape. Random count brings the total to about 1950 requests.
  localparam int unsigned RANDOM_REQS     = 1928;
  localparam int unsigned HOT_SLOTS       = 8;       // small working set so values build up
  localparam int unsigned HOLD_OFF_CYCLES = 600;     // long result back-pressure
  localparam int unsigned HOLD_OFF_AFTER  = 300;     // requests sent before the hold-off
  localparam int unsigned QUIET_FROM      = 800;     // window with no idling on either side
  localparam int unsigned QUIET_TO        = 1000;
  localparam int unsigned DRAIN_CYCLES    = 100;     // extra wait after the last expected result
  // Worst case covers busy time, send gaps and result stalls per request,
  // plus the clear sweep and the hold-off; this limit is several times that.
  localparam int unsigned CYCLE_LIMIT     = 1200000;

  // Opcodes past OP_COPY are unused and must act as a no-op.
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd10;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] src_a;
    logic [SLOT_W-1:0] src_b;
    logic [SLOT_W-1:0] dest;
    logic [TGT_W-1:0]  target_a;
    logic [TGT_W-1:0]  target_b;
  } instr_t;

  typedef struct packed {
    logic [OUT_PC_W-1:0] pc;
    logic [WORD_W-1:0]   value;
    logic                wrote;
  } outcome_t;

  // One row of the directed plan; 'known' rows carry a hand-written outcome.
  typedef struct packed {
    instr_t   instr;
    logic     known;
    outcome_t want;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     opcode = '0;
  logic [SLOT_W-1:0]   src_a = '0;
  logic [SLOT_W-1:0]   src_b = '0;
  logic [SLOT_W-1:0]   dest = '0;
  logic [TGT_W-1:0]    target_a = '0;
  logic [TGT_W-1:0]    target_b = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [OUT_PC_W-1:0] pc_value;
  logic [WORD_W-1:0]   written_value;
  logic                wrote;

  // Shadow architectural state, kept in step with every accepted request.
  logic [WORD_W-1:0]       shadow_regs [DEF_NUM_REGS];
  logic [DEF_PC_WIDTH-1:0] shadow_pc;

  outcome_t    pending_results [$];
  plan_row_t   directed_plan [$];
  int unsigned fail_count = 0;
  int unsigned sent_count = 0;
  int unsigned cycle_count = 0;
  outcome_t    oldest;

  vm_register_alu_branch_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .src_a         (src_a),
    .src_b         (src_b),
    .dest          (dest),
    .target_a      (target_a),
    .target_b      (target_b),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pc_value      (pc_value),
    .written_value (written_value),
    .wrote         (wrote)
  );

  always #2 clk = ~clk;

  // Global watchdog; also covers results that never show up.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --- shadow register file access: out-of-range slots read 0, writes dropped
  function automatic logic [WORD_W-1:0] read_slot(logic [SLOT_W-1:0] slot);
    if (slot >= DEF_NUM_REGS) return '0;
    return shadow_regs[slot];
  endfunction

  function automatic bit write_slot(logic [SLOT_W-1:0] slot, logic [WORD_W-1:0] v);
    if (slot >= DEF_NUM_REGS) return 1'b0;
    shadow_regs[slot] = v;
    return 1'b1;
  endfunction

  // Executes one instruction on the shadow state and returns its outcome.
  function automatic outcome_t execute_instr(instr_t ins);
    logic [WORD_W-1:0] va;
    logic [WORD_W-1:0] vb;
    logic [WORD_W-1:0] v;
    bit                did;
    outcome_t          res;
    va  = read_slot(ins.src_a);
    vb  = read_slot(ins.src_b);
    v   = '0;
    did = 1'b0;
    case (ins.op)
      OP_CMP: begin
        // flag always lands in register 0
        v   = (va == vb) ? 64'd1 : 64'd0;
        did = write_slot('0, v);
      end
      OP_BEQ:  shadow_pc = (va == vb) ? ins.target_a : ins.target_b;
      OP_BNE:  shadow_pc = (va != vb) ? ins.target_a : ins.target_b;
      OP_JUMP: shadow_pc = ins.target_a;
      OP_ADD: begin
        v   = va + vb;
        did = write_slot(ins.dest, v);
      end
      OP_SUB: begin
        v   = va - vb;
        did = write_slot(ins.dest, v);
      end
      OP_MUL: begin
        v   = va * vb;
        did = write_slot(ins.dest, v);
      end
      OP_DIV: begin
        v   = (vb == '0) ? '0 : va / vb;
        did = write_slot(ins.dest, v);
      end
      OP_MOVE: begin
        // copy first, clear second: a move onto itself leaves zero
        did = write_slot(ins.src_b, va);
        void'(write_slot(ins.src_a, '0));
        v   = read_slot(ins.src_b);
      end
      OP_COPY: begin
        did = write_slot(ins.src_b, va);
        v   = va;
      end
      default: ;
    endcase
    res.pc    = OUT_PC_W'(shadow_pc);
    res.value = did ? v : '0;
    res.wrote = did;
    return res;
  endfunction

  // Mostly short idles, some medium, a few long.
  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Slots cluster on a few hot registers so arithmetic chains build real
  // values; the rest span the whole slot range.
  function automatic logic [SLOT_W-1:0] pick_slot();
    if ($urandom_range(0, 99) < 80) return SLOT_W'($urandom_range(0, HOT_SLOTS - 1));
    return SLOT_W'($urandom_range(0, (1 << SLOT_W) - 1));
  endfunction

  function automatic logic [TGT_W-1:0] pick_target();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return TGT_W'($urandom);
  endfunction

  function automatic instr_t random_instr();
    instr_t ins;
    if ($urandom_range(0, 99) < 92)
      ins.op = OP_W'($urandom_range(int'(OP_CMP), int'(OP_COPY)));
    else
      ins.op = OP_W'($urandom_range(int'(OP_UNUSED_LO), int'(OP_UNUSED_HI)));
    ins.src_a    = pick_slot();
    ins.src_b    = pick_slot();
    ins.dest     = pick_slot();
    ins.target_a = pick_target();
    ins.target_b = pick_target();
    return ins;
  endfunction

  task automatic add_row(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] sa,
                         input logic [SLOT_W-1:0] sb, input logic [SLOT_W-1:0] sd,
                         input logic [TGT_W-1:0] ta, input logic [TGT_W-1:0] tb,
                         input logic known, input logic [OUT_PC_W-1:0] pc,
                         input logic [WORD_W-1:0] v, input logic w);
    plan_row_t row;
    row.instr = '{op, sa, sb, sd, ta, tb};
    row.known = known;
    row.want  = '{pc, v, w};
    directed_plan.push_back(row);
  endtask

  // Presents one request and holds it until the block takes it. The
  // expectation is queued at the accepting edge, so queue order is
  // acceptance order. 'given' overrides the prediction for typed rows;
  // the shadow state advances either way.
  task automatic send_instr(input instr_t ins, input logic known, input outcome_t given);
    int unsigned gap;
    outcome_t    predicted;
    gap = (sent_count >= QUIET_FROM && sent_count < QUIET_TO) ? 0 : pause_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= ins.op;
    src_a    <= ins.src_a;
    src_b    <= ins.src_b;
    dest     <= ins.dest;
    target_a <= ins.target_a;
    target_b <= ins.target_b;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = execute_instr(ins);
    pending_results.push_back(known ? given : predicted);
    sent_count++;
  endtask

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: pc_value=%h written_value=%h wrote=%b",
               pc_value, written_value, wrote);
        fail_count++;
      end else begin
        oldest = pending_results.pop_front();
        if (pc_value !== oldest.pc) begin
          $error("pc_value: expected %h, got %h", oldest.pc, pc_value);
          fail_count++;
        end
        if (written_value !== oldest.value) begin
          $error("written_value: expected %h, got %h", oldest.value, written_value);
          fail_count++;
        end
        if (wrote !== oldest.wrote) begin
          $error("wrote: expected %b, got %b", oldest.wrote, wrote);
          fail_count++;
        end
      end
    end
  end

  // Result back-pressure. One long hold-off fills the block so it has to
  // stall its request side; no stall during the quiet window.
  initial begin
    bit          held_off;
    int unsigned n;
    held_off = 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (!held_off && sent_count >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        n = HOLD_OFF_CYCLES;
      end else if (sent_count >= QUIET_FROM && sent_count < QUIET_TO) begin
        n = 0;
      end else begin
        n = pause_len();
      end
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  initial begin
    plan_row_t row;
    instr_t    ins;
    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    shadow_pc = '0;

    // Directed plan. Registers start at zero, pc at zero.
    // compare flag: equal zeros -> r0 = 1
    add_row(OP_CMP,  8'd1,   8'd2,   8'd0,   32'h0,        32'h0,        1'b1, 32'h0,
            64'd1, 1'b1);
    add_row(OP_BEQ,  8'd3,   8'd4,   8'd0,   32'hFFFFFFFF, 32'h0,        1'b1, 32'hFFFFFFFF,
            64'd0, 1'b0);
    // equal operands, so not-equal falls through to target_b
    add_row(OP_BNE,  8'd3,   8'd4,   8'd0,   32'h12345678, 32'h0,        1'b1, 32'h0,
            64'd0, 1'b0);
    add_row(OP_JUMP, 8'd0,   8'd0,   8'd0,   32'hA5A5A5A5, 32'h5A5A5A5A, 1'b1, 32'hA5A5A5A5,
            64'd0, 1'b0);
    add_row(OP_ADD,  8'd0,   8'd0,   8'd5,   32'h0,        32'h0,        1'b1, 32'hA5A5A5A5,
            64'd2, 1'b1);
    // 0 - 1 wraps to all ones
    add_row(OP_SUB,  8'd6,   8'd0,   8'd7,   32'h0,        32'h0,        1'b1, 32'hA5A5A5A5,
            64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    add_row(OP_MUL,  8'd7,   8'd7,   8'd8,   32'h0,        32'h0,        1'b1, 32'hA5A5A5A5,
            64'd1, 1'b1);
    // zero divisor writes zero
    add_row(OP_DIV,  8'd7,   8'd6,   8'd9,   32'h0,        32'h0,        1'b1, 32'hA5A5A5A5,
            64'd0, 1'b1);
    add_row(OP_DIV,  8'd7,   8'd5,   8'd10,  32'h0,        32'h0,        1'b1, 32'hA5A5A5A5,
            64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
    add_row(OP_MUL,  8'd7,   8'd5,   8'd11,  32'h0,        32'h0,        1'b1, 32'hA5A5A5A5,
            64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
    add_row(OP_ADD,  8'd7,   8'd0,   8'd12,  32'h0,        32'h0,        1'b1, 32'hA5A5A5A5,
            64'd0, 1'b1);
    add_row(OP_COPY, 8'd7,   8'd255, 8'd0,   32'h0,        32'h0,        1'b1, 32'hA5A5A5A5,
            64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    add_row(OP_MOVE, 8'd255, 8'd254, 8'd0,   32'h0,        32'h0,        1'b1, 32'hA5A5A5A5,
            64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    // move onto itself ends at zero
    add_row(OP_MOVE, 8'd254, 8'd254, 8'd0,   32'h0,        32'h0,        1'b1, 32'hA5A5A5A5,
            64'd0, 1'b1);
    add_row(OP_BEQ,  8'd255, 8'd254, 8'd0,   32'h1,        32'hFFFFFFFF, 1'b1, 32'h1,
            64'd0, 1'b0);
    add_row(OP_BNE,  8'd7,   8'd0,   8'd0,   32'hFFFFFFFE, 32'h0,        1'b1, 32'hFFFFFFFE,
            64'd0, 1'b0);
    // unequal compare clears the flag, still reports a write
    add_row(OP_CMP,  8'd7,   8'd8,   8'd0,   32'h0,        32'h0,        1'b1, 32'hFFFFFFFE,
            64'd0, 1'b1);
    add_row(OP_UNUSED_LO, 8'd7, 8'd7, 8'd7,  32'h0,        32'h0,        1'b1, 32'hFFFFFFFE,
            64'd0, 1'b0);
    add_row(OP_UNUSED_HI, 8'hFF, 8'hFF, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFE,
            64'd0, 1'b0);
    add_row(OP_DIV,  8'd11,  8'd10,  8'd255, 32'h0,        32'h0,        1'b1, 32'hFFFFFFFE,
            64'd2, 1'b1);
    add_row(OP_JUMP, 8'd0,   8'd0,   8'd0,   32'h0,        32'hFFFFFFFF, 1'b1, 32'h0,
            64'd0, 1'b0);
    add_row(OP_MUL,  8'd10,  8'd10,  8'd0,   32'h0,        32'h0,        1'b0, '0, '0, 1'b0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      send_instr(row.instr, row.known, row.want);
    end
    repeat (RANDOM_REQS) begin
      ins = random_instr();
      send_instr(ins, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
